// File: src/bdm_pkg.sv
package bdm_pkg;

  localparam int WORD_W   = 64;
  localparam int IN_WORDS = 4;
  localparam int INDEX_W  = 6;
  localparam int MEDIAN_W = 9;
  localparam int POP_W    = 7;

  typedef struct packed {
    logic calc;
    logic count;
    logic merge;
    logic rotate;
  } cell_ctrl_t;

  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] x;
    x = v - ((v >> 1) & 64'h5555555555555555);
    x = (x & 64'h3333333333333333) + ((x >> 2) & 64'h3333333333333333);
    x = (x + (x >> 4)) & 64'h0F0F0F0F0F0F0F0F;
    x = x + (x >> 8);
    x = x + (x >> 16);
    x = x + (x >> 32);
    return x[POP_W-1:0];
  endfunction

endpackage

// File: src/bdm_cell.sv
module bdm_cell #(
  parameter int DESC_WORDS = 4,
  parameter int MAX_DESC   = 64
) (
  input  logic                                               clk,
  input  bdm_pkg::cell_ctrl_t                                ctrl,
  input  logic                                               wr_en,
  input  logic [DESC_WORDS*bdm_pkg::WORD_W-1:0]              load_data,
  input  logic [DESC_WORDS*bdm_pkg::WORD_W-1:0]              cand,
  input  logic [DESC_WORDS*bdm_pkg::WORD_W-1:0]              nb_desc,
  input  logic [$clog2(DESC_WORDS*bdm_pkg::WORD_W+1)-1:0]    nb_ring,
  input  logic [$clog2(DESC_WORDS*bdm_pkg::WORD_W+1)-1:0]    nb_merge,
  input  logic [$clog2(MAX_DESC+1)-1:0]                      k,
  output logic [DESC_WORDS*bdm_pkg::WORD_W-1:0]              desc,
  output logic [$clog2(DESC_WORDS*bdm_pkg::WORD_W+1)-1:0]    ring,
  output logic [$clog2(DESC_WORDS*bdm_pkg::WORD_W+1)-1:0]    merge
);
  import bdm_pkg::*;

  localparam int DESC_W = DESC_WORDS * WORD_W;
  localparam int DIST_W = $clog2(DESC_W + 1);
  localparam int CNT_W  = $clog2(MAX_DESC + 1);

  logic [DIST_W-1:0] d;
  logic [DIST_W-1:0] dist_now;
  logic [CNT_W-1:0]  lt;
  logic [CNT_W-1:0]  le;
  logic              q;

  always_comb begin
    dist_now = '0;
    for (int w = 0; w < DESC_WORDS; w++) begin
      dist_now = dist_now + DIST_W'(pop64(desc[w*WORD_W +: WORD_W] ^ cand[w*WORD_W +: WORD_W]));
    end
  end

  assign q = (lt <= k) && (le > k);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      desc <= load_data;
    end else if (ctrl.rotate) begin
      desc <= nb_desc;
    end
    if (ctrl.calc) begin
      d     <= dist_now;
      ring  <= dist_now;
      lt    <= '0;
      le    <= '0;
      merge <= '0;
    end else if (ctrl.count) begin
      lt   <= lt + CNT_W'(ring < d);
      le   <= le + CNT_W'(ring <= d);
      ring <= nb_ring;
    end else if (ctrl.merge) begin
      merge <= nb_merge | (q ? d : '0);
    end
  end

endmodule

// File: src/binary_descriptor_median_medoid.sv
// Hamming medoid by lower median distance. Descriptors load one word per cycle, while no
// result is stalled on out_ready, into a row of cells, up to MAX_DESC of them; unusable
// words are skipped and words beyond capacity are dropped and reported in overflowed. A
// word with last_item starts the selection. Each candidate takes a distance step for all
// distances in parallel, a count phase for the distance ring to rotate through the cells
// that count ranks, a merge phase for the median to shift down the chain and a compare
// step. No input is taken during selection. With nothing kept, or with the discarded flag
// (cfg_write_data) set, the result comes back on the cycle after the last word.
module binary_descriptor_median_medoid #(
  parameter int MAX_DESC   = 64,
  parameter int DESC_WORDS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic                              cfg_write_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bdm_pkg::WORD_W-1:0]        word0,
  input  logic [bdm_pkg::WORD_W-1:0]        word1,
  input  logic [bdm_pkg::WORD_W-1:0]        word2,
  input  logic [bdm_pkg::WORD_W-1:0]        word3,
  input  logic                              usable,
  input  logic                              last_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [bdm_pkg::INDEX_W-1:0]       best_index,
  output logic [bdm_pkg::MEDIAN_W-1:0]      best_median,
  output logic [bdm_pkg::WORD_W-1:0]        best_word0,
  output logic [bdm_pkg::WORD_W-1:0]        best_word1,
  output logic [bdm_pkg::WORD_W-1:0]        best_word2,
  output logic [bdm_pkg::WORD_W-1:0]        best_word3,
  output logic                              overflowed
);
  import bdm_pkg::*;

  localparam int DESC_W = DESC_WORDS * WORD_W;
  localparam int DIST_W = $clog2(DESC_W + 1);
  localparam int CNT_W  = $clog2(MAX_DESC + 1);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_DIST  = 5'b00010,
    S_COUNT = 5'b00100,
    S_MERGE = 5'b01000,
    S_STEP  = 5'b10000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  kept;
  logic              ovf;
  logic              discarded;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  cyc;
  logic [CNT_W-1:0]  cand_idx;
  logic              set_ovf;
  logic [DIST_W:0]   best;
  logic [CNT_W-1:0]  best_pos;
  logic [DESC_W-1:0] best_desc;
  logic [DESC_W-1:0] out_desc;

  logic              in_acc;
  logic              has_room;
  logic              keep_it;
  logic [CNT_W-1:0]  kept_next;
  logic              ovf_next;
  logic              better;
  logic [DIST_W:0]   fin_med;
  logic [CNT_W-1:0]  fin_pos;
  logic [DESC_W-1:0] fin_desc;
  logic [CNT_W-1:0]  n_last;

  cell_ctrl_t        ctrl;
  logic [WORD_W-1:0] in_word [IN_WORDS];
  logic [DESC_W-1:0] load_data;
  logic [DESC_W-1:0] desc     [MAX_DESC];
  logic [DESC_W-1:0] nb_desc  [MAX_DESC];
  logic [DIST_W-1:0] ring     [MAX_DESC];
  logic [DIST_W-1:0] nb_ring  [MAX_DESC];
  logic [DIST_W-1:0] merge    [MAX_DESC];
  logic [DIST_W-1:0] nb_merge [MAX_DESC];

  assign in_word[0] = word0;
  assign in_word[1] = word1;
  assign in_word[2] = word2;
  assign in_word[3] = word3;

  for (genvar w = 0; w < DESC_WORDS; w++) begin : g_load
    if (w < IN_WORDS) begin : g_in
      assign load_data[w*WORD_W +: WORD_W] = in_word[w];
    end else begin : g_zero
      assign load_data[w*WORD_W +: WORD_W] = '0;
    end
  end

  for (genvar w = 0; w < IN_WORDS; w++) begin : g_out
    logic [WORD_W-1:0] word;
    if (w < DESC_WORDS) begin : g_have
      assign word = out_desc[w*WORD_W +: WORD_W];
    end else begin : g_zero
      assign word = '0;
    end
  end
  assign best_word0 = g_out[0].word;
  assign best_word1 = g_out[1].word;
  assign best_word2 = g_out[2].word;
  assign best_word3 = g_out[3].word;

  assign in_ready  = (state == S_LOAD) && (!out_valid || out_ready);
  assign in_acc    = in_valid && in_ready;
  assign has_room  = kept < CNT_W'(MAX_DESC);
  assign keep_it   = in_acc && usable && has_room;
  assign kept_next = kept + CNT_W'(keep_it);
  assign ovf_next  = ovf | (in_acc && usable && !has_room);
  assign n_last    = n - CNT_W'(1);

  assign ctrl.calc   = (state == S_DIST);
  assign ctrl.count  = (state == S_COUNT);
  assign ctrl.merge  = (state == S_MERGE);
  assign ctrl.rotate = (state == S_STEP);

  assign better   = {1'b0, merge[0]} < best;
  assign fin_med  = better ? {1'b0, merge[0]} : best;
  assign fin_pos  = better ? cand_idx : best_pos;
  assign fin_desc = better ? desc[0] : best_desc;

  for (genvar j = 0; j < MAX_DESC; j++) begin : g_cell
    if (j == MAX_DESC - 1) begin : g_end
      assign nb_desc[j]  = desc[0];
      assign nb_ring[j]  = ring[0];
      assign nb_merge[j] = '0;
    end else begin : g_mid
      assign nb_desc[j]  = (CNT_W'(j) == n_last) ? desc[0] : desc[j+1];
      assign nb_ring[j]  = (CNT_W'(j) == n_last) ? ring[0] : ring[j+1];
      assign nb_merge[j] = (CNT_W'(j) >= n_last) ? '0 : merge[j+1];
    end

    bdm_cell #(
      .DESC_WORDS(DESC_WORDS),
      .MAX_DESC  (MAX_DESC)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .wr_en    (keep_it && (kept == CNT_W'(j))),
      .load_data(load_data),
      .cand     (desc[0]),
      .nb_desc  (nb_desc[j]),
      .nb_ring  (nb_ring[j]),
      .nb_merge (nb_merge[j]),
      .k        (k),
      .desc     (desc[j]),
      .ring     (ring[j]),
      .merge    (merge[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      kept      <= '0;
      ovf       <= 1'b0;
      discarded <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        discarded <= cfg_write_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (last_item) begin
              kept    <= '0;
              ovf     <= 1'b0;
              n       <= kept_next;
              k       <= (kept_next - CNT_W'(1)) >> 1;
              set_ovf <= ovf_next;
              if (kept_next == '0 || discarded) begin
                out_valid   <= 1'b1;
                found       <= 1'b0;
                best_index  <= '0;
                best_median <= '0;
                out_desc    <= '0;
                overflowed  <= ovf_next;
              end else begin
                state    <= S_DIST;
                cand_idx <= '0;
                best     <= '1;
              end
            end else begin
              kept <= kept_next;
              ovf  <= ovf_next;
            end
          end
        end
        S_DIST: begin
          state <= S_COUNT;
          cyc   <= '0;
        end
        S_COUNT: begin
          cyc <= cyc + CNT_W'(1);
          if (cyc == n_last) begin
            state <= S_MERGE;
            cyc   <= '0;
          end
        end
        S_MERGE: begin
          cyc <= cyc + CNT_W'(1);
          if (cyc == n_last) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          best      <= fin_med;
          best_pos  <= fin_pos;
          best_desc <= fin_desc;
          if (cand_idx == n_last) begin
            state       <= S_LOAD;
            out_valid   <= 1'b1;
            found       <= 1'b1;
            best_index  <= INDEX_W'(fin_pos);
            best_median <= MEDIAN_W'(fin_med);
            out_desc    <= fin_desc;
            overflowed  <= set_ovf;
          end else begin
            state    <= S_DIST;
            cand_idx <= cand_idx + CNT_W'(1);
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// File: src/bdm_checker.sv
module bdm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         last_item,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         found,
  input logic [bdm_pkg::INDEX_W-1:0]  best_index,
  input logic [bdm_pkg::MEDIAN_W-1:0] best_median,
  input logic [bdm_pkg::WORD_W-1:0]   best_word0
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_index) && $stable(best_median))
    else $error("result word changed while stalled");

  a_rise_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && last_item) || !$past(in_ready))
    else $error("result without a last word or selection");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> best_index == '0 && best_median == '0 && best_word0 == '0)
    else $error("empty result carries data");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_item |=> out_valid || !in_ready)
    else $error("neither result nor selection after last word");

endmodule

bind binary_descriptor_median_medoid bdm_checker u_bdm_checker (.*);
